### design/telemetry_path_interpolator_defines.svh
// Assertion macros shared by the checker of the telemetry path interpolator.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef TELEMETRY_PATH_INTERPOLATOR_DEFINES_SVH
`define TELEMETRY_PATH_INTERPOLATOR_DEFINES_SVH

// Next-cycle implication, ignored while reset is high
`define TPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpi check failed");

// Next-cycle implication, checked during reset as well
`define TPI_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tpi check failed");

`endif

### design/tpi_pkg.sv
// Shared types and constants of the telemetry path interpolator.
// Used by the controller, the datapath and the top level.
package tpi_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 64;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int IN_DATA_W   = 144;
  localparam int OUT_DATA_W  = 80;

  typedef struct packed {
    logic [31:0] time_value;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] driven;
    logic [15:0] speed;
    logic [31:0] path;
  } row_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_PREP, S_LD_SQ, S_LD_SUM, S_LD_SQRT, S_LD_WR,
    S_Q_INIT, S_T_RD, S_T_CMP, S_B_RD0, S_B_RD1, S_B_CAP,
    S_D_DIFF, S_D_MUL, S_D_DIV, S_D_SAT,
    S_P_RD, S_P_CMP, S_J_RD0, S_J_RD1, S_J_CAP,
    S_R_PREP, S_R_DIV, S_L_MUL, S_L_ADD, S_EMIT_MOVED, S_EMIT_HELD
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_LD_PREP, OP_LD_SQ, OP_LD_FULL, OP_LD_SUM,
    OP_SQRT_STEP, OP_LD_WR, OP_Q_INIT, OP_T_RD, OP_K_INC,
    OP_B_RD0, OP_B_RD1, OP_B_CAP, OP_D_DIFF, OP_D_MUL, OP_DIV_STEP,
    OP_D_SAT, OP_P_RD, OP_J_INC, OP_J_RD0, OP_J_RD1, OP_J_CAP,
    OP_R_PREP, OP_L_MUL, OP_L_ADD, OP_EMIT_MOVED, OP_EMIT_HELD
  } op_t;

  typedef struct packed {
    logic n_ge2;
    logic full;
    logic k_more;
    logic t_less;
    logic j_more;
    logic p_less;
    logic trivial;
    logic p_gt;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### design/tpi_ctrl.sv
// Sequencer of the telemetry path interpolator: load and query steps.
// Depends on tpi_pkg; drives the datapath by one op code per cycle.
module tpi_ctrl import tpi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_query,
  output logic    in_ready,
  input  status_t status,
  output op_t     op
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = in_query ? S_Q_INIT : S_LD_PREP;
      S_LD_PREP:    state_next = S_LD_SQ;
      S_LD_SQ:      state_next = status.full ? S_IDLE : S_LD_SUM;
      S_LD_SUM:     state_next = S_LD_SQRT;
      S_LD_SQRT:    if (status.sqrt_done) state_next = S_LD_WR;
      S_LD_WR:      state_next = S_IDLE;
      S_Q_INIT:     state_next = status.n_ge2 ? S_T_RD : S_EMIT_HELD;
      S_T_RD:       state_next = status.k_more ? S_T_CMP : S_B_RD0;
      S_T_CMP:      state_next = status.t_less ? S_T_RD : S_B_RD0;
      S_B_RD0:      state_next = S_B_RD1;
      S_B_RD1:      state_next = S_B_CAP;
      S_B_CAP:      state_next = S_D_DIFF;
      S_D_DIFF:     state_next = S_D_MUL;
      S_D_MUL:      state_next = status.trivial ? S_P_RD : S_D_DIV;
      S_D_DIV:      if (status.div_done) state_next = S_D_SAT;
      S_D_SAT:      state_next = S_P_RD;
      S_P_RD:       state_next = status.j_more ? S_P_CMP : S_EMIT_HELD;
      S_P_CMP:      state_next = status.p_less ? S_P_RD : S_J_RD0;
      S_J_RD0:      state_next = S_J_RD1;
      S_J_RD1:      state_next = S_J_CAP;
      S_J_CAP:      state_next = S_R_PREP;
      S_R_PREP:     state_next = status.p_gt ? S_R_DIV : S_L_MUL;
      S_R_DIV:      if (status.div_done) state_next = S_L_MUL;
      S_L_MUL:      state_next = S_L_ADD;
      S_L_ADD:      state_next = S_EMIT_MOVED;
      S_EMIT_MOVED: if (status.out_free) state_next = S_IDLE;
      S_EMIT_HELD:  if (status.out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_CAPTURE;
      end
      S_LD_PREP:    op = OP_LD_PREP;
      S_LD_SQ:      op = status.full ? OP_LD_FULL : OP_LD_SQ;
      S_LD_SUM:     op = OP_LD_SUM;
      S_LD_SQRT:    op = OP_SQRT_STEP;
      S_LD_WR:      op = OP_LD_WR;
      S_Q_INIT:     op = OP_Q_INIT;
      S_T_RD:       op = status.k_more ? OP_T_RD : OP_NONE;
      S_T_CMP:      op = status.t_less ? OP_K_INC : OP_NONE;
      S_B_RD0:      op = OP_B_RD0;
      S_B_RD1:      op = OP_B_RD1;
      S_B_CAP:      op = OP_B_CAP;
      S_D_DIFF:     op = OP_D_DIFF;
      S_D_MUL:      op = OP_D_MUL;
      S_D_DIV:      op = OP_DIV_STEP;
      S_D_SAT:      op = OP_D_SAT;
      S_P_RD:       op = status.j_more ? OP_P_RD : OP_NONE;
      S_P_CMP:      op = status.p_less ? OP_J_INC : OP_NONE;
      S_J_RD0:      op = OP_J_RD0;
      S_J_RD1:      op = OP_J_RD1;
      S_J_CAP:      op = OP_J_CAP;
      S_R_PREP:     op = OP_R_PREP;
      S_R_DIV:      op = OP_DIV_STEP;
      S_L_MUL:      op = OP_L_MUL;
      S_L_ADD:      op = OP_L_ADD;
      S_EMIT_MOVED: op = status.out_free ? OP_EMIT_MOVED : OP_NONE;
      S_EMIT_HELD:  op = status.out_free ? OP_EMIT_HELD : OP_NONE;
      default:      op = OP_NONE;
    endcase
  end

endmodule

### design/tpi_datapath.sv
// Datapath of the telemetry path interpolator: sample memory, square root,
// shared divider, multipliers and the output register. Depends on tpi_pkg.
module tpi_datapath import tpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  op_t                   op,
  output status_t               status,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_moved
);

  row_t             mem [MAX_SAMPLES];
  row_t             rd_row, lo_row, hi_row;
  logic [IDX_W-1:0] rd_addr;

  logic [31:0] cap_time, cap_x, cap_y, cap_drv;
  logic [15:0] cap_spd;
  logic        cap_last;

  logic [CNT_W-1:0] count, k, j;
  logic             closed;
  logic [31:0]      prev_x, prev_y, prev_path;

  logic [32:0] mx, my;
  logic        negx, negy;
  logic [63:0] sq_x, sq_y;
  logic        sq_ovf;
  logic [63:0] sr_rem, sr_res, sr_bit;
  logic [STEP_W-1:0] step;

  logic [31:0] dt_m, dd_m, den_m;
  logic        neg, trivial;
  logic [63:0] dq;
  logic [31:0] drem, dvs;
  logic [31:0] drv_pos;
  logic [63:0] prod_x, prod_y;

  logic [31:0] held_x, held_y;
  logic [15:0] held_spd;

  // Combinational helpers
  logic [32:0] dx_d, dy_d, t_d, tt_d, d_d, px_d, py_d;
  logic [64:0] sq_sum, sr_trial;
  logic [32:0] drem2, drem_sub;
  logic        div_ge;
  logic [32:0] path_sum;
  logic [31:0] seg, num, pden, offx, offy;

  assign dx_d = {cap_x[31], cap_x} - {prev_x[31], prev_x};
  assign dy_d = {cap_y[31], cap_y} - {prev_y[31], prev_y};
  assign sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};
  assign sr_trial = {1'b0, sr_res} + {1'b0, sr_bit};
  assign seg      = sq_ovf ? 32'hFFFF_FFFF : sr_res[31:0];
  assign path_sum = {1'b0, prev_path} + {1'b0, seg};

  assign t_d  = {1'b0, hi_row.time_value} - {1'b0, lo_row.time_value};
  assign tt_d = {1'b0, cap_time} - {1'b0, lo_row.time_value};
  assign d_d  = {1'b0, hi_row.driven} - {1'b0, lo_row.driven};
  assign px_d = {hi_row.coord_x[31], hi_row.coord_x} - {lo_row.coord_x[31], lo_row.coord_x};
  assign py_d = {hi_row.coord_y[31], hi_row.coord_y} - {lo_row.coord_y[31], lo_row.coord_y};

  assign drem2    = {drem, dq[63]};
  assign div_ge   = drem2 >= {1'b0, dvs};
  assign drem_sub = drem2 - {1'b0, dvs};

  assign pden = hi_row.path - lo_row.path;
  assign num  = (drv_pos <= lo_row.path) ? 32'd0 :
                ((drv_pos - lo_row.path) > pden ? pden : drv_pos - lo_row.path);

  assign offx = (mx[32] ? dq[31:0] : 32'd0) + (dq[32] ? mx[31:0] : prod_x[63:32]);
  assign offy = (my[32] ? dq[31:0] : 32'd0) + (dq[32] ? my[31:0] : prod_y[63:32]);

  // Status toward the controller
  always_comb begin
    status.n_ge2     = count >= CNT_W'(2);
    status.full      = count == CNT_W'(MAX_SAMPLES);
    status.k_more    = ((CNT_W+1)'(k) + (CNT_W+1)'(2)) < (CNT_W+1)'(count);
    status.t_less    = rd_row.time_value < cap_time;
    status.j_more    = ((CNT_W+1)'(j) + (CNT_W+1)'(1)) < (CNT_W+1)'(count);
    status.p_less    = rd_row.path < drv_pos;
    status.trivial   = trivial;
    status.p_gt      = hi_row.path > lo_row.path;
    status.sqrt_done = step == STEP_W'(SQRT_STEPS - 1);
    status.div_done  = step == STEP_W'(DIV_STEPS - 1);
    status.out_free  = !out_valid || out_ready;
  end

  // Read address of the sample memory
  always_comb begin
    unique case (op)
      OP_T_RD, OP_B_RD1: rd_addr = IDX_W'(k + CNT_W'(1));
      OP_B_RD0:          rd_addr = k[IDX_W-1:0];
      OP_P_RD, OP_J_RD1: rd_addr = IDX_W'(j + CNT_W'(1));
      OP_J_RD0:          rd_addr = j[IDX_W-1:0];
      default:           rd_addr = '0;
    endcase
  end

  // Sample memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (op == OP_LD_WR) begin
      mem[count[IDX_W-1:0]] <= '{time_value: cap_time, coord_x: cap_x, coord_y: cap_y,
                                 driven: cap_drv, speed: cap_spd,
                                 path: (count == '0) ? 32'd0 :
                                       (path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0])};
    end
    rd_row <= mem[rd_addr];
  end

  // Control state: table fill, close flag, held result, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      closed    <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
      held_spd  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise on a new result, drop once the receiver takes it
      if (op == OP_EMIT_MOVED || op == OP_EMIT_HELD) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (op)
        OP_LD_PREP: if (closed) begin
          count  <= '0;
          closed <= 1'b0;
        end
        OP_LD_FULL: if (cap_last) closed <= 1'b1;
        OP_LD_WR: begin
          count <= count + CNT_W'(1);
          if (cap_last) closed <= 1'b1;
        end
        OP_L_ADD: begin
          held_x   <= negx ? lo_row.coord_x - offx : lo_row.coord_x + offx;
          held_y   <= negy ? lo_row.coord_y - offy : lo_row.coord_y + offy;
          held_spd <= lo_row.speed;
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the arithmetic steps
  always_ff @(posedge clk) begin
    unique case (op)
      OP_CAPTURE: begin
        cap_time <= in_data[31:0];
        cap_x    <= in_data[63:32];
        cap_y    <= in_data[95:64];
        cap_drv  <= in_data[127:96];
        cap_spd  <= in_data[143:128];
        cap_last <= in_last;
      end
      OP_LD_PREP: begin
        mx <= dx_d[32] ? -dx_d : dx_d;
        my <= dy_d[32] ? -dy_d : dy_d;
      end
      OP_LD_SQ: begin
        sq_x   <= mx[31:0] * mx[31:0];
        sq_y   <= my[31:0] * my[31:0];
        sq_ovf <= mx[32] | my[32];
      end
      OP_LD_SUM: begin
        sq_ovf <= sq_ovf | sq_sum[64];
        sr_rem <= sq_sum[63:0];
        sr_res <= '0;
        sr_bit <= 64'd1 << 62;
        step   <= '0;
      end
      OP_SQRT_STEP: begin
        // one bit pair of the square root
        if ({1'b0, sr_rem} >= sr_trial) begin
          sr_rem <= sr_rem - sr_trial[63:0];
          sr_res <= (sr_res >> 1) + sr_bit;
        end else begin
          sr_res <= sr_res >> 1;
        end
        sr_bit <= sr_bit >> 2;
        step   <= step + STEP_W'(1);
      end
      OP_LD_WR: begin
        prev_x    <= cap_x;
        prev_y    <= cap_y;
        prev_path <= (count == '0) ? 32'd0 :
                     (path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0]);
      end
      OP_Q_INIT: begin
        k <= '0;
        j <= '0;
      end
      OP_K_INC: k <= k + CNT_W'(1);
      OP_J_INC: j <= j + CNT_W'(1);
      OP_B_RD1, OP_J_RD1: lo_row <= rd_row;
      OP_B_CAP, OP_J_CAP: hi_row <= rd_row;
      OP_D_DIFF: begin
        den_m   <= t_d[32] ? 32'(-t_d) : t_d[31:0];
        dt_m    <= tt_d[32] ? 32'(-tt_d) : tt_d[31:0];
        dd_m    <= d_d[32] ? 32'(-d_d) : d_d[31:0];
        neg     <= (tt_d[32] ^ d_d[32]) ^ t_d[32];
        trivial <= (t_d == '0) || (tt_d == '0) || (d_d == '0);
      end
      OP_D_MUL: begin
        if (trivial) drv_pos <= lo_row.driven;
        dq   <= dt_m * dd_m;
        dvs  <= den_m;
        drem <= '0;
        step <= '0;
      end
      OP_DIV_STEP: begin
        // one quotient bit per cycle
        drem <= div_ge ? drem_sub[31:0] : drem2[31:0];
        dq   <= {dq[62:0], div_ge};
        step <= step + STEP_W'(1);
      end
      OP_D_SAT: begin
        if (neg) begin
          drv_pos <= (dq > {32'd0, lo_row.driven}) ? 32'd0 : lo_row.driven - dq[31:0];
        end else begin
          drv_pos <= (dq > {32'd0, ~lo_row.driven}) ? 32'hFFFF_FFFF
                                                    : lo_row.driven + dq[31:0];
        end
      end
      OP_R_PREP: begin
        mx   <= px_d[32] ? -px_d : px_d;
        my   <= py_d[32] ? -py_d : py_d;
        negx <= px_d[32];
        negy <= py_d[32];
        dq   <= status.p_gt ? {num, 32'd0} : 64'd0;
        dvs  <= pden;
        drem <= '0;
        step <= '0;
      end
      OP_L_MUL: begin
        prod_x <= mx[31:0] * dq[31:0];
        prod_y <= my[31:0] * dq[31:0];
      end
      OP_EMIT_MOVED, OP_EMIT_HELD: begin
        out_data  <= {held_spd, held_y, held_x};
        out_moved <= (op == OP_EMIT_MOVED);
      end
      default: ;
    endcase
  end

endmodule

### design/telemetry_path_interpolator.sv
// Top level of the telemetry path interpolator.
// Depends on tpi_pkg, tpi_ctrl and tpi_datapath.
//
// Usage:
//   Slave channel: one item per handshake. tuser = func (0 load, 1 query),
//   tlast = last_sample. Loads append a sample to the table; a load with
//   tlast closes the table and the next load starts a fresh one.
//   Master channel: one item per query, none per load. tuser = moved.
//   Work per item:
//   A load is dominated by the 32-step square root.
//   A query grows with k and j, the final time and path bracket indexes:
//   two linear searches through the single memory read port, and the
//   shared 64-step divider used up to twice.
//   One item is worked at a time; s_tready is high only when idle.
// Reset: rst clears the table fill, close flag and held position to zero;
//   the sample memory keeps its contents and needs no clearing.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its result waits until the register is taken.
module telemetry_path_interpolator import tpi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // time_value[31:0], coord_x[63:32], coord_y[95:64], driven_dist[127:96],
  // speed_in[143:128]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x[31:0], out_y[63:32], out_speed[79:64]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // moved
  output logic                  m_tuser
);

  op_t     op;
  status_t status;

  tpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_query (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  tpi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_moved (m_tuser)
  );

endmodule

### design/tpi_checker.sv
// Port-level checks of the telemetry path interpolator, bound to the top.
// Depends on tpi_pkg and telemetry_path_interpolator_defines.svh.
`include "telemetry_path_interpolator_defines.svh"

module tpi_checker import tpi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A result waiting for the receiver holds its value
  `TPI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // An accepted item makes the block busy for the next cycle
  `TPI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // A load never raises a result right after it is taken
  `TPI_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && !s_tuser, !$rose(m_tvalid))

  // Reset empties the output register
  `TPI_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid)

endmodule

bind telemetry_path_interpolator tpi_checker u_tpi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/telemetry_path_interpolator_tb.sv
// Self-checking testbench for the telemetry path interpolator.
// Loads sample tables, queries positions, and compares every result with a local model.
// Depends on tpi_pkg and the telemetry_path_interpolator RTL.
`timescale 1ns / 1ps

module telemetry_path_interpolator_tb;
  import tpi_pkg::*;

  localparam bit FN_LOAD  = 1'b0;
  localparam bit FN_QUERY = 1'b1;

  typedef struct {
    bit        fn;
    bit [31:0] tv;
    bit [31:0] cx;
    bit [31:0] cy;
    bit [31:0] dd;
    bit [15:0] spd;
    bit        lst;
  } sample_item_t;

  typedef struct {
    bit [31:0] px;
    bit [31:0] py;
    bit [15:0] spd;
    bit        moved;
  } position_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  telemetry_path_interpolator dut (.*);

  always #4 clk = ~clk;

  // local copy of the sample table
  bit [31:0] tbl_time [MAX_SAMPLES];
  bit [31:0] tbl_x [MAX_SAMPLES];
  bit [31:0] tbl_y [MAX_SAMPLES];
  bit [31:0] tbl_drv [MAX_SAMPLES];
  bit [15:0] tbl_spd [MAX_SAMPLES];
  bit [31:0] tbl_len [MAX_SAMPLES];
  int        fill_cnt;
  bit        closed;
  bit [31:0] hold_x, hold_y;
  bit [15:0] hold_spd;

  position_t    pending_pos[$];
  sample_item_t stim[$];
  int errors, n_loads, n_queries, n_moved, n_results;
  bit rx_holdoff, random_idle;

  task automatic report(input string what, input bit [31:0] got, input bit [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  function automatic bit [31:0] isqrt(input bit [127:0] v);
    bit [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo[31:0];
  endfunction

  function automatic bit [31:0] seg_length(input int i);
    longint ax, ay;
    bit [127:0] mx, my, sq;
    ax = longint'($signed(tbl_x[i])) - longint'($signed(tbl_x[i-1]));
    ay = longint'($signed(tbl_y[i])) - longint'($signed(tbl_y[i-1]));
    mx = 128'(ax < 0 ? -ax : ax);
    my = 128'(ay < 0 ? -ay : ay);
    sq = mx * mx + my * my;
    if (sq >= (128'd1 << 64)) return 32'hFFFF_FFFF;
    return isqrt(sq);
  endfunction

  function automatic bit [31:0] lerp(input bit [31:0] c0, input bit [31:0] c1,
                                     input bit [63:0] r);
    longint a, d;
    bit [127:0] m, off;
    a = longint'($signed(c0));
    d = longint'($signed(c1)) - a;
    m = (d < 0) ? 128'(-d) : 128'(d);
    off = (m * r) >> 32;
    return (d < 0) ? 32'(a - longint'(off)) : 32'(a + longint'(off));
  endfunction

  function automatic bit [31:0] dist_at(input bit [31:0] t, input int k);
    longint den, dt, ddf;
    bit [127:0] q;
    bit neg;
    bit [31:0] d0;
    d0 = tbl_drv[k];
    den = longint'(tbl_time[k+1]) - longint'(tbl_time[k]);
    dt = longint'(t) - longint'(tbl_time[k]);
    ddf = longint'(tbl_drv[k+1]) - longint'(d0);
    if (den == 0 || dt == 0 || ddf == 0) return d0;
    q = (128'(dt < 0 ? -dt : dt) * 128'(ddf < 0 ? -ddf : ddf)) / 128'(den < 0 ? -den : den);
    neg = ((dt < 0) != (ddf < 0)) != (den < 0);
    if (neg) return (q > d0) ? 32'd0 : 32'(d0 - q);
    return (q > 128'(32'hFFFF_FFFF - d0)) ? 32'hFFFF_FFFF : 32'(d0 + q);
  endfunction

  // advance the local table or compute the expected position
  function automatic void predict_position(input sample_item_t it);
    position_t p;
    int k, j;
    bit [31:0] drv_pos, p0, p1, s;
    bit [63:0] r, num;
    if (it.fn == FN_LOAD) begin
      if (closed) begin
        fill_cnt = 0;
        closed = 0;
      end
      if (fill_cnt < MAX_SAMPLES) begin
        tbl_time[fill_cnt] = it.tv;
        tbl_x[fill_cnt] = it.cx;
        tbl_y[fill_cnt] = it.cy;
        tbl_drv[fill_cnt] = it.dd;
        tbl_spd[fill_cnt] = it.spd;
        if (fill_cnt == 0) tbl_len[0] = 0;
        else begin
          s = seg_length(fill_cnt);
          tbl_len[fill_cnt] = (s > 32'hFFFF_FFFF - tbl_len[fill_cnt-1]) ? 32'hFFFF_FFFF
                                                                          : tbl_len[fill_cnt-1] + s;
        end
        fill_cnt++;
      end
      if (it.lst) closed = 1;
      return;
    end
    p.moved = 0;
    if (fill_cnt >= 2) begin
      k = 0;
      while (k + 2 < fill_cnt && tbl_time[k+1] < it.tv) k++;
      drv_pos = dist_at(it.tv, k);
      j = 0;
      while (j + 1 < fill_cnt && tbl_len[j+1] < drv_pos) j++;
      if (j + 1 < fill_cnt) begin
        p0 = tbl_len[j];
        p1 = tbl_len[j+1];
        r = 0;
        if (p1 > p0) begin
          num = (drv_pos > p0) ? 64'(drv_pos - p0) : 64'd0;
          if (num > 64'(p1 - p0)) num = 64'(p1 - p0);
          r = (num << 32) / 64'(p1 - p0);
        end
        hold_x = lerp(tbl_x[j], tbl_x[j+1], r);
        hold_y = lerp(tbl_y[j], tbl_y[j+1], r);
        hold_spd = tbl_spd[j];
        p.moved = 1;
      end
    end
    p.px = hold_x;
    p.py = hold_y;
    p.spd = hold_spd;
    pending_pos.push_back(p);
  endfunction

  function automatic sample_item_t mk(input bit fn, input bit [31:0] tv, input bit [31:0] cx,
                                      input bit [31:0] cy, input bit [31:0] dd,
                                      input bit [15:0] spd, input bit lst);
    sample_item_t it;
    it.fn = fn; it.tv = tv; it.cx = cx; it.cy = cy; it.dd = dd; it.spd = spd; it.lst = lst;
    return it;
  endfunction

  function automatic bit [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // lap: rising times, non-decreasing distances, a moving path (random if wild), then queries
  task automatic add_lap(input int n, input int nq, input bit wild);
    bit [31:0] t, d, x, y;
    t = $urandom_range(0, 1000);
    d = $urandom_range(0, 50000);
    x = $urandom();
    y = $urandom();
    for (int i = 0; i < n; i++) begin
      if (wild) stim.push_back(mk(FN_LOAD, rnd32(), rnd32(), rnd32(), rnd32(),
                                  16'($urandom()), i == n - 1));
      else stim.push_back(mk(FN_LOAD, t, x, y, d, 16'($urandom()), i == n - 1));
      t += $urandom_range(1, 200);
      d += $urandom_range(0, 32'h0008_0000);
      x += $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      y += $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    end
    for (int q = 0; q < nq; q++)
      stim.push_back(mk(FN_QUERY, (q % 5 == 4) ? rnd32() : $urandom_range(0, t + 300),
                        $urandom(), $urandom(), $urandom(), 16'($urandom()),
                        1'($urandom_range(0, 1))));
  endtask

  // directed rows; known results given where obvious
  sample_item_t dir_rows[$];
  position_t    dir_want[$];
  bit           dir_has[$];

  task automatic dir(input sample_item_t it, input bit has, input position_t w);
    dir_rows.push_back(it);
    dir_has.push_back(has);
    dir_want.push_back(w);
  endtask

  // sender
  initial begin
    position_t none, held0, got;
    int idx, j;
    none = '{32'h0, 32'h0, 16'h0, 1'b0};
    held0 = '{32'h0, 32'h0, 16'h0, 1'b0};
    // query after reset: held zeros, not moved
    dir(mk(FN_QUERY, 32'd100, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1, held0);
    dir(mk(FN_LOAD, 32'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b0, none);
    // a single sample still cannot move
    dir(mk(FN_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1, held0);
    dir(mk(FN_LOAD, 32'd1000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 16'hFFFF, 1'b1),
        1'b0, none);
    // 3-4-5 segment; start, end and middle of the segment
    dir(mk(FN_QUERY, 32'd0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1,
        '{32'h0, 32'h0, 16'h0, 1'b1});
    dir(mk(FN_QUERY, 32'd1000, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1), 1'b1,
        '{32'h0003_0000, 32'h0004_0000, 16'h0, 1'b1});
    dir(mk(FN_QUERY, 32'd500, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1,
        '{32'h0001_8000, 32'h0002_0000, 16'h0, 1'b1});
    // past the end keeps the midpoint from the row above
    dir(mk(FN_QUERY, 32'd2000, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1,
        '{32'h0001_8000, 32'h0002_0000, 16'h0, 1'b0});
    // fresh table with extreme coordinates, two equal times and then time zero
    dir(mk(FN_LOAD, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h1234,
           1'b0), 1'b0, none);
    dir(mk(FN_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0001, 1'b0),
        1'b0, none);
    dir(mk(FN_LOAD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 16'hAAAA, 1'b1),
        1'b0, none);
    dir(mk(FN_QUERY, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b0, none);
    dir(mk(FN_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b0, none);
    dir(mk(FN_QUERY, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b0, none);
    // zero-length path: repeated positions
    dir(mk(FN_LOAD, 32'd10, 32'h0001_0000, 32'h0001_0000, 32'd0, 16'd7, 1'b0), 1'b0, none);
    dir(mk(FN_LOAD, 32'd20, 32'h0001_0000, 32'h0001_0000, 32'd0, 16'd8, 1'b1), 1'b0, none);
    dir(mk(FN_QUERY, 32'd15, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0), 1'b1,
        '{32'h0001_0000, 32'h0001_0000, 16'd7, 1'b1});
    foreach (dir_rows[i]) stim.push_back(dir_rows[i]);
    // random: mostly well-formed laps, some wild tables and stray queries
    while (stim.size() < dir_rows.size() + 270) begin
      case ($urandom_range(0, 9))
        0: add_lap($urandom_range(1, 4), $urandom_range(1, 3), 1);
        1: stim.push_back(mk(FN_QUERY, rnd32(), rnd32(), rnd32(), rnd32(),
                             16'($urandom()), 1'b0));
        default: add_lap($urandom_range(2, 12), $urandom_range(2, 8), 0);
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idx = 0;
    j = 0;
    while (idx < stim.size()) begin
      predict_position(stim[idx]);
      if (idx < dir_rows.size() && dir_has[idx]) begin
        // expected values typed in; the model must agree with them
        got = pending_pos[$];
        if (got.px !== dir_want[idx].px) report("typed out_x", got.px, dir_want[idx].px);
        if (got.py !== dir_want[idx].py) report("typed out_y", got.py, dir_want[idx].py);
        if (got.spd !== dir_want[idx].spd)
          report("typed out_speed", 32'(got.spd), 32'(dir_want[idx].spd));
        if (got.moved !== dir_want[idx].moved)
          report("typed moved", 32'(got.moved), 32'(dir_want[idx].moved));
      end
      if (stim[idx].fn == FN_LOAD) n_loads++;
      else n_queries++;
      if (random_idle && $urandom_range(0, 99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tuser <= stim[idx].fn;
      s_tlast <= stim[idx].lst;
      s_tdata <= {stim[idx].spd, stim[idx].dd, stim[idx].cy, stim[idx].cx, stim[idx].tv};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      idx++;
    end
    s_tvalid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    $display("covered %0d loads and %0d queries, %0d results of which %0d moved",
             n_loads, n_queries, n_results, n_moved);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // idling mode: a quiet stretch with no idling, then random gaps
  initial begin
    random_idle = 1'b0;
    wait (!rst);
    repeat (3000) @(posedge clk);
    random_idle = 1'b1;
  end

  // long receiver hold-off so results back up and input stalls
  initial begin
    rx_holdoff = 1'b0;
    wait (!rst);
    repeat (1000) @(posedge clk);
    rx_holdoff = 1'b1;
    repeat (800) @(posedge clk);
    rx_holdoff = 1'b0;
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !rx_holdoff && !(random_idle && $urandom_range(0, 99) < 14);
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    position_t w;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_pos.size() == 0) begin
        report("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        w = pending_pos.pop_front();
        if (m_tdata[31:0] !== w.px) report("out_x", m_tdata[31:0], w.px);
        if (m_tdata[63:32] !== w.py) report("out_y", m_tdata[63:32], w.py);
        if (m_tdata[79:64] !== w.spd) report("out_speed", 32'(m_tdata[79:64]), 32'(w.spd));
        if (m_tuser !== w.moved) report("moved", 32'(m_tuser), 32'(w.moved));
        if (w.moved) n_moved++;
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
